// File: hdl/msd_pkg.sv
`default_nettype none
package msd_pkg;
	localparam int MAX_ATOMS  = 1024;
	localparam int MAX_STARTS = 16;
	localparam int SLOT_W     = 10;
	localparam int START_W    = 4;
	localparam int CNT_W      = 5;
	localparam int REF_AW     = SLOT_W + START_W;

	localparam logic [2:0] REG_BOX_X    = 3'd0;
	localparam logic [2:0] REG_BOX_Y    = 3'd1;
	localparam logic [2:0] REG_BOX_Z    = 3'd2;
	localparam logic [2:0] REG_GROUP    = 3'd3;
	localparam logic [2:0] REG_STARTS   = 3'd4;
	localparam logic [2:0] REG_INTERVAL = 3'd5;
	localparam logic [2:0] REG_LIMIT    = 3'd6;

	typedef struct packed {
		logic [SLOT_W-1:0]  atom_slot;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [31:0]        frame_time;
		logic               frame_end;
	} atom_t;

	typedef struct packed {
		logic [START_W-1:0] start_index;
		logic [15:0]        lag_frames;
		logic [61:0]        msd_value;
		logic               last_result;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [10:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [61:0] quotient;
	} div_rsp_t;

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction
endpackage
`default_nettype wire

// File: hdl/msd_if.sv
`default_nettype none
interface atom_if;
	logic                 valid;
	logic                 ready;
	msd_pkg::atom_t       data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface result_if;
	logic                 valid;
	logic                 ready;
	msd_pkg::result_t     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/msd_accumulate_with_unwrap_top.sv
`default_nettype none
// Mean square displacement accumulator. Each input transaction carries one atom
// position. From the second frame on, the block unwraps the position against the
// stored previous position, then at the first atom of a frame opens a start point
// when one is due, and adds the squared displacement from each active start
// reference. An atom occupies the block from its acceptance to the next possible
// acceptance for the previous-position read, the unwrap of each axis (a 35-step
// restoring division by twice the box length; a zero box length leaves the axis
// as it is), the start check and the write-back, and per active start the
// reference read, read data, square and accumulate steps, then a return to idle.
// In the first frame nothing is unwrapped. On the last atom of a frame each
// active start then yields one result from a serial division by group_size, and
// the frame is then closed. A result waits while the previous one has not been
// taken, and no atom is accepted while a result is pending. Previous and
// reference positions sit in synchronous memories and need no clearing.
module msd_accumulate_with_unwrap_top (
	input  wire        clk,
	input  wire        arst_n,
	atom_if.sink       atom_in,
	result_if.source   result_out,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [4:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	import msd_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREV  = 4'd1;
	localparam logic [3:0] ST_UNW   = 4'd2;
	localparam logic [3:0] ST_SAT   = 4'd3;
	localparam logic [3:0] ST_OPEN  = 4'd4;
	localparam logic [3:0] ST_RREQ  = 4'd5;
	localparam logic [3:0] ST_RDAT  = 4'd6;
	localparam logic [3:0] ST_SQ    = 4'd7;
	localparam logic [3:0] ST_ACC   = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_DWAIT = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;
	localparam logic [3:0] ST_END   = 4'd12;

	// configuration
	logic [30:0] box_x_q, box_y_q, box_z_q;
	logic [10:0] group_q;
	logic [4:0]  starts_cfg_q;
	logic [31:0] interval_q;
	logic [15:0] limit_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q      <= 31'd65536;
			box_y_q      <= 31'd65536;
			box_z_q      <= 31'd65536;
			group_q      <= 11'd1;
			starts_cfg_q <= 5'd1;
			interval_q   <= 32'd2560;
			limit_q      <= 16'd10;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			case (reg_idx)
				REG_BOX_X:    box_x_q      <= pwdata[30:0];
				REG_BOX_Y:    box_y_q      <= pwdata[30:0];
				REG_BOX_Z:    box_z_q      <= pwdata[30:0];
				REG_GROUP:    group_q      <= pwdata[10:0];
				REG_STARTS:   starts_cfg_q <= pwdata[4:0];
				REG_INTERVAL: interval_q   <= pwdata;
				REG_LIMIT:    limit_q      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BOX_X:    prdata = {1'b0, box_x_q};
			REG_BOX_Y:    prdata = {1'b0, box_y_q};
			REG_BOX_Z:    prdata = {1'b0, box_z_q};
			REG_GROUP:    prdata = {21'd0, group_q};
			REG_STARTS:   prdata = {27'd0, starts_cfg_q};
			REG_INTERVAL: prdata = interval_q;
			REG_LIMIT:    prdata = {16'd0, limit_q};
			default:      prdata = '0;
		endcase
	end

	// memories
	logic signed [31:0] prev_mem [MAX_ATOMS][3];
	logic signed [31:0] ref_mem  [MAX_STARTS*MAX_ATOMS][3];
	logic [63:0]        sum_mem  [MAX_STARTS];
	logic [15:0]        sfrm_mem [MAX_STARTS];

	// control state
	logic [3:0]          state_q;
	logic [CNT_W-1:0]    taken_q;
	logic [15:0]         frame_q;
	logic [31:0]         first_q;
	logic                in_frame_q;
	logic [START_W-1:0]  n_q;
	logic                out_valid_q;
	result_t             out_q;

	// item registers
	atom_t               item_q;
	logic signed [31:0]  prv_q [3];
	logic signed [31:0]  u_q [3];
	logic signed [31:0]  rf_q [3];
	logic [63:0]         sq_q [3];
	logic [1:0]          ax_q;

	div_req_t            dreq;
	div_rsp_t            drsp;

	msd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [4:0]  lim;
	logic        active;
	logic [REF_AW-1:0] ref_addr;
	logic [30:0] box_sel;
	logic signed [31:0] cur_pos;
	logic signed [33:0] dd;
	logic signed [34:0] nnum;
	logic [33:0] ad, bd, cd;
	logic [32:0] am, bm, cm;
	logic [63:0] s_all;
	logic [63:0] tprod;
	logic [64:0] tgoal;

	assign lim      = (starts_cfg_q > 5'(MAX_STARTS)) ? 5'(MAX_STARTS) : starts_cfg_q;
	assign active   = frame_q < limit_q;
	assign ref_addr = {n_q, item_q.atom_slot};
	assign atom_in.ready = (state_q == ST_IDLE) && !out_valid_q;

	always_comb begin
		case (ax_q)
			2'd0:    box_sel = box_x_q;
			2'd1:    box_sel = box_y_q;
			default: box_sel = box_z_q;
		endcase
	end

	always_comb begin
		case (ax_q)
			2'd0:    cur_pos = item_q.pos_x;
			2'd1:    cur_pos = item_q.pos_y;
			default: cur_pos = item_q.pos_z;
		endcase
	end

	// unwrap one axis at a time: q = floor((2d + b - 1) / 2b) from a restoring
	// division of |2d + b - 1| by 2b, then u = cur - q*b, saturated
	assign dd   = 34'(cur_pos) - 34'(prv_q[ax_q]);
	assign nnum = (35'(dd) <<< 1) + 35'(box_sel) - 35'sd1;

	assign am = 33'(u_q[0]) - 33'(rf_q[0]);
	assign bm = 33'(u_q[1]) - 33'(rf_q[1]);
	assign cm = 33'(u_q[2]) - 33'(rf_q[2]);
	assign ad = {1'b0, am[32] ? 33'(-$signed(am)) : am};
	assign bd = {1'b0, bm[32] ? 33'(-$signed(bm)) : bm};
	assign cd = {1'b0, cm[32] ? 33'(-$signed(cm)) : cm};
	assign s_all = sat_add64(sat_add64(sq_q[0], sq_q[1]), sq_q[2]);

	assign tprod = 64'(taken_q) * 64'(interval_q);
	assign tgoal = 65'(first_q) + 65'(tprod);

	// unwrap: u = cur - q*b, q = floor(n / 2b). Formed one quotient bit per cycle
	// through a restoring division on |n| held in uquo_q and urem_q.
	logic [6:0]  ucnt_q;
	logic [34:0] urem_q;
	logic [34:0] uquo_q;
	logic        uneg_q;
	logic [35:0] utrial;
	logic signed [66:0] qb;
	logic signed [35:0] qsigned;

	assign utrial  = {urem_q, uquo_q[34]} - {4'd0, box_sel, 1'b0};
	assign qsigned = uneg_q ? ((urem_q != 0) ? -36'(uquo_q) - 36'sd1 : -36'(uquo_q))
	                        : 36'(uquo_q);
	assign qb      = 67'(qsigned) * 67'(box_sel);

	logic signed [66:0] qb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			taken_q     <= '0;
			frame_q     <= '0;
			first_q     <= '0;
			in_frame_q  <= 1'b0;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			ax_q        <= '0;
			ucnt_q      <= '0;
			for (int i = 0; i < MAX_STARTS; i++) begin
				sum_mem[i]  <= '0;
				sfrm_mem[i] <= '0;
			end
		end else begin
			if (out_valid_q && result_out.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (atom_in.valid && atom_in.ready && active)
					state_q <= ST_PREV;
				ST_PREV: begin
					ax_q    <= '0;
					state_q <= (frame_q == 16'd0) ? ST_OPEN : ST_UNW;
				end
				ST_UNW: begin
					if (ucnt_q == 7'd0) begin
						if (box_sel == 31'd0)
							ucnt_q <= 7'd100;
						else
							ucnt_q <= 7'd36;
					end else if (ucnt_q == 7'd100 || ucnt_q == 7'd1) begin
						ucnt_q  <= 7'd0;
						state_q <= ST_SAT;
					end else begin
						ucnt_q <= ucnt_q - 7'd1;
					end
				end
				ST_SAT: begin
					if (ax_q == 2'd2) begin
						state_q <= ST_OPEN;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= ST_UNW;
					end
				end
				ST_OPEN: begin
					if (!in_frame_q) begin
						in_frame_q <= 1'b1;
						if (frame_q == 16'd0)
							first_q <= item_q.frame_time;
						if (taken_q < lim && 65'(item_q.frame_time) >=
							((frame_q == 16'd0) ? 65'(item_q.frame_time) + 65'(tprod) : tgoal)) begin
							sfrm_mem[taken_q[START_W-1:0]] <= frame_q;
							sum_mem[taken_q[START_W-1:0]]  <= '0;
							taken_q <= taken_q + 5'd1;
						end
					end
					n_q     <= '0;
					state_q <= ST_RREQ;
				end
				ST_RREQ: begin
					if (5'(n_q) >= taken_q)
						state_q <= item_q.frame_end ? ST_DIV : ST_IDLE;
					else
						state_q <= ST_RDAT;
					if (5'(n_q) >= taken_q && item_q.frame_end)
						n_q <= '0;
				end
				ST_RDAT: state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_ACC;
				ST_ACC: begin
					sum_mem[n_q] <= sat_add64(sum_mem[n_q], s_all);
					if (5'(n_q) + 5'd1 >= taken_q)
						state_q <= item_q.frame_end ? ST_DIV : ST_IDLE;
					else
						state_q <= ST_RREQ;
					n_q <= (5'(n_q) + 5'd1 >= taken_q) ? '0 : n_q + START_W'(1);
				end
				ST_DIV: begin
					if (taken_q == 5'd0) begin
						if (frame_q != 16'hFFFF)
							frame_q <= frame_q + 16'd1;
						in_frame_q <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_DWAIT;
					end
				end
				ST_DWAIT: if (drsp.done) state_q <= ST_OUT;
				ST_OUT: if (!out_valid_q) begin
					out_valid_q  <= 1'b1;
					sum_mem[n_q] <= '0;
					if (5'(n_q) + 5'd1 >= taken_q) begin
						n_q     <= '0;
						state_q <= ST_END;
					end else begin
						n_q     <= n_q + START_W'(1);
						state_q <= ST_DIV;
					end
				end
				ST_END: begin
					if (frame_q != 16'hFFFF)
						frame_q <= frame_q + 16'd1;
					in_frame_q <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// unwrap divider and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: item_q <= atom_in.data;
			ST_PREV: begin
				prv_q[0] <= prev_mem[item_q.atom_slot][0];
				prv_q[1] <= prev_mem[item_q.atom_slot][1];
				prv_q[2] <= prev_mem[item_q.atom_slot][2];
				u_q[0]   <= item_q.pos_x;
				u_q[1]   <= item_q.pos_y;
				u_q[2]   <= item_q.pos_z;
			end
			ST_UNW: begin
				if (ucnt_q == 7'd0) begin
					uneg_q <= nnum[34];
					uquo_q <= nnum[34] ? 35'(-nnum) : 35'(nnum);
					urem_q <= '0;
				end else if (ucnt_q != 7'd100 && ucnt_q != 7'd1) begin
					if (!utrial[35]) begin
						urem_q <= utrial[34:0];
						uquo_q <= {uquo_q[33:0], 1'b1};
					end else begin
						urem_q <= {urem_q[33:0], uquo_q[34]};
						uquo_q <= {uquo_q[33:0], 1'b0};
					end
				end else if (ucnt_q == 7'd1) begin
					qb_q <= qb;
				end else begin
					qb_q <= '0;
				end
			end
			ST_SAT: begin
				if (67'(cur_pos) - qb_q > 67'sd2147483647)
					u_q[ax_q] <= 32'sh7FFFFFFF;
				else if (67'(cur_pos) - qb_q < -67'sd2147483648)
					u_q[ax_q] <= 32'sh80000000;
				else
					u_q[ax_q] <= 32'(67'(cur_pos) - qb_q);
			end
			ST_OPEN: begin
				prev_mem[item_q.atom_slot][0] <= u_q[0];
				prev_mem[item_q.atom_slot][1] <= u_q[1];
				prev_mem[item_q.atom_slot][2] <= u_q[2];
			end
			ST_RREQ: begin
				if (5'(n_q) + 5'd1 == taken_q && sfrm_mem[n_q] == frame_q) begin
					ref_mem[ref_addr][0] <= u_q[0];
					ref_mem[ref_addr][1] <= u_q[1];
					ref_mem[ref_addr][2] <= u_q[2];
					rf_q <= u_q;
				end else begin
					rf_q[0] <= ref_mem[ref_addr][0];
					rf_q[1] <= ref_mem[ref_addr][1];
					rf_q[2] <= ref_mem[ref_addr][2];
				end
			end
			ST_RDAT: begin
				sq_q[0] <= 64'(ad[32:0]) * 64'(ad[32:0]);
				sq_q[1] <= 64'(bd[32:0]) * 64'(bd[32:0]);
				sq_q[2] <= 64'(cd[32:0]) * 64'(cd[32:0]);
			end
			ST_OUT: if (!out_valid_q) begin
				out_q.start_index <= n_q;
				out_q.lag_frames  <= frame_q - sfrm_mem[n_q];
				out_q.msd_value   <= drsp.quotient;
				out_q.last_result <= (5'(n_q) + 5'd1 == taken_q);
			end
			default: ;
		endcase
	end

	assign dreq.start    = (state_q == ST_DIV) && taken_q != 5'd0 && 5'(n_q) < taken_q;
	assign dreq.dividend = sum_mem[n_q];
	assign dreq.divisor  = group_q;

	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		atom_in.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_taken_cap: assert property (@(posedge clk) disable iff (!arst_n)
		taken_q <= 5'(MAX_STARTS)) else $error("start count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_out.ready |=> out_valid_q) else $error("result dropped");
endmodule
`default_nettype wire

// File: hdl/msd_div.sv
`default_nettype none
// Restoring divider of a 64-bit dividend, one quotient bit per cycle.
module msd_div (
	input  wire               clk,
	input  wire               arst_n,
	input  msd_pkg::div_req_t req,
	output msd_pkg::div_rsp_t rsp
);
	import msd_pkg::*;

	logic [63:0] quo_q;
	logic [10:0] rem_q;
	logic [10:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [11:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= (req.divisor == 11'd0) ? 11'd1 : req.divisor;
		end else if (busy_q) begin
			if (!trial[11]) begin
				rem_q <= trial[10:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[9:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = (quo_q[63:62] != 2'b00) ? {62{1'b1}} : quo_q[61:0];

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider busy at done");
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 7'd0) else $error("divider counter empty while busy");
endmodule
`default_nettype wire

// File: dv/tb_msd_accumulate_with_unwrap_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_msd_accumulate_with_unwrap_top;
	import msd_pkg::*;

	localparam int  POOL_N     = 4;
	localparam longint LIMIT_CYCLES = 3000000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	atom_if   atom_ch ();
	result_if res_ch ();

	msd_accumulate_with_unwrap_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.atom_in    (atom_ch),
		.result_out (res_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// register copies held by the predictor
	logic [30:0] box_x_r, box_y_r, box_z_r;
	logic [10:0] group_r;
	logic [4:0]  starts_r;
	logic [31:0] interval_r;
	logic [15:0] limit_r;

	// displacement state
	logic signed [31:0] last_px [MAX_ATOMS];
	logic signed [31:0] last_py [MAX_ATOMS];
	logic signed [31:0] last_pz [MAX_ATOMS];
	logic signed [31:0] anchor_x [MAX_STARTS][MAX_ATOMS];
	logic signed [31:0] anchor_y [MAX_STARTS][MAX_ATOMS];
	logic signed [31:0] anchor_z [MAX_STARTS][MAX_ATOMS];
	logic [63:0] disp_sum [MAX_STARTS];
	logic [15:0] opened_at [MAX_STARTS];
	logic [4:0]  opened_cnt;
	logic [15:0] frames_done;
	logic [31:0] origin_time;
	logic        mid_frame;

	atom_t   pending_atoms [$];
	result_t msd_due [$];

	// raw coordinates last sent per slot, for generating nearby moves
	logic signed [31:0] sent_x [MAX_ATOMS];
	logic signed [31:0] sent_y [MAX_ATOMS];
	logic signed [31:0] sent_z [MAX_ATOMS];
	logic [SLOT_W-1:0] pool [POOL_N];

	int     sender_idle, recv_idle;
	int     errors;
	longint cycles = 0;

	function automatic logic signed [31:0] unwrap_coord(longint cur, longint prv,
			logic [30:0] b);
		longint bb, d, n, m, q, u;
		bb = longint'(b);
		if (b == 0)
			u = cur;
		else begin
			d = cur - prv;
			n = 2 * d + bb - 1;
			m = 2 * bb;
			q = n / m;
			if (n % m != 0 && n < 0)
				q = q - 1;
			u = cur - q * bb;
		end
		if (u > 64'sd2147483647)
			u = 64'sd2147483647;
		if (u < -64'sd2147483648)
			u = -64'sd2147483648;
		return u[31:0];
	endfunction

	function automatic logic [63:0] sq_dist(logic signed [31:0] a, logic signed [31:0] b);
		longint d;
		logic [63:0] mag;
		d = longint'(a) - longint'(b);
		if (d < 0)
			d = -d;
		mag = d;
		return mag * mag;
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	task automatic predict_msd(input atom_t a);
		logic [SLOT_W-1:0] slot;
		logic signed [31:0] px, py, pz;
		logic [4:0]  lim;
		logic [63:0] s, q;
		logic [10:0] gs;
		result_t r;
		if (frames_done >= limit_r)
			return;
		slot = a.atom_slot;
		px = a.pos_x;
		py = a.pos_y;
		pz = a.pos_z;
		if (frames_done > 0) begin
			px = unwrap_coord(longint'(px), longint'(last_px[slot]), box_x_r);
			py = unwrap_coord(longint'(py), longint'(last_py[slot]), box_y_r);
			pz = unwrap_coord(longint'(pz), longint'(last_pz[slot]), box_z_r);
		end
		last_px[slot] = px;
		last_py[slot] = py;
		last_pz[slot] = pz;
		if (!mid_frame) begin
			mid_frame = 1'b1;
			if (frames_done == 0)
				origin_time = a.frame_time;
			lim = (starts_r > MAX_STARTS) ? 5'(MAX_STARTS) : starts_r;
			if (opened_cnt < lim && {32'd0, a.frame_time} >=
					{32'd0, origin_time} + 64'(opened_cnt) * 64'(interval_r)) begin
				opened_at[opened_cnt] = frames_done;
				disp_sum[opened_cnt] = '0;
				opened_cnt = opened_cnt + 5'd1;
			end
		end
		if (opened_cnt > 0 && opened_at[opened_cnt-1] == frames_done) begin
			anchor_x[opened_cnt-1][slot] = px;
			anchor_y[opened_cnt-1][slot] = py;
			anchor_z[opened_cnt-1][slot] = pz;
		end
		for (int n = 0; n < opened_cnt; n++) begin
			s = add_sat(sq_dist(anchor_x[n][slot], px), sq_dist(anchor_y[n][slot], py));
			s = add_sat(s, sq_dist(anchor_z[n][slot], pz));
			disp_sum[n] = add_sat(disp_sum[n], s);
		end
		if (a.frame_end) begin
			gs = (group_r == 0) ? 11'd1 : group_r;
			for (int n = 0; n < opened_cnt; n++) begin
				q = disp_sum[n] / 64'(gs);
				if (q > 64'h3FFF_FFFF_FFFF_FFFF)
					q = 64'h3FFF_FFFF_FFFF_FFFF;
				r.start_index = n[START_W-1:0];
				r.lag_frames  = frames_done - opened_at[n];
				r.msd_value   = q[61:0];
				r.last_result = (n + 1 == opened_cnt);
				msd_due.push_back(r);
				disp_sum[n] = '0;
			end
			if (frames_done < 16'hFFFF)
				frames_done = frames_done + 16'd1;
			mid_frame = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	// atom driver
	always @(posedge clk) begin
		if (!arst_n)
			atom_ch.valid <= 1'b0;
		else if (atom_ch.valid && !atom_ch.ready)
			atom_ch.valid <= 1'b1;
		else if (pending_atoms.size() != 0 && $urandom_range(99) >= sender_idle) begin
			atom_ch.valid <= 1'b1;
			atom_ch.data  <= pending_atoms.pop_front();
		end else
			atom_ch.valid <= 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	// input monitor feeds the predictor
	always @(posedge clk) begin
		if (arst_n && atom_ch.valid && atom_ch.ready)
			predict_msd(atom_ch.data);
	end

	// result monitor
	always @(posedge clk) begin
		result_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (msd_due.size() == 0) begin
				report_mismatch("unexpected result", 64'(res_ch.data.start_index), 64'd0);
			end else begin
				w = msd_due.pop_front();
				if (res_ch.data.start_index !== w.start_index)
					report_mismatch("start_index", 64'(res_ch.data.start_index),
						64'(w.start_index));
				if (res_ch.data.lag_frames !== w.lag_frames)
					report_mismatch("lag_frames", 64'(res_ch.data.lag_frames),
						64'(w.lag_frames));
				if (res_ch.data.msd_value !== w.msd_value)
					report_mismatch("msd_value", 64'(res_ch.data.msd_value),
						64'(w.msd_value));
				if (res_ch.data.last_result !== w.last_result)
					report_mismatch("last_result", 64'(res_ch.data.last_result),
						64'(w.last_result));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_BOX_X:    box_x_r    = val[30:0];
			REG_BOX_Y:    box_y_r    = val[30:0];
			REG_BOX_Z:    box_z_r    = val[30:0];
			REG_GROUP:    group_r    = val[10:0];
			REG_STARTS:   starts_r   = val[4:0];
			REG_INTERVAL: interval_r = val;
			REG_LIMIT:    limit_r    = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [31:0] bx, input logic [31:0] by,
			input logic [31:0] bz, input logic [31:0] gs, input logic [31:0] ns,
			input logic [31:0] iv, input logic [31:0] lim);
		write_reg(REG_BOX_X, bx);
		write_reg(REG_BOX_Y, by);
		write_reg(REG_BOX_Z, bz);
		write_reg(REG_GROUP, gs);
		write_reg(REG_STARTS, ns);
		write_reg(REG_INTERVAL, iv);
		write_reg(REG_LIMIT, lim);
	endtask

	// wait out the block, including frames that produce nothing: ready stays low
	// until the last transaction has left the block
	task automatic drain();
		while (pending_atoms.size() != 0 || atom_ch.valid)
			@(posedge clk);
		while (msd_due.size() != 0)
			@(posedge clk);
		while (!atom_ch.ready)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic signed [31:0] edge_coord(int k);
		case (k % 4)
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh0000_0000;
			default: return -32'sd1;
		endcase
	endfunction

	function automatic logic signed [31:0] move_coord(logic signed [31:0] last);
		int r;
		r = $urandom_range(9);
		if (r < 6)
			return last + $signed($urandom_range(262144)) - 32'sd131072;
		else if (r < 8)
			return $urandom;
		else
			return edge_coord($urandom_range(3));
	endfunction

	// every frame visits the whole slot pool, so no unwritten entry is read
	task automatic add_frame(input logic [31:0] t, input bit directed, input int k);
		logic [SLOT_W-1:0] slots [$];
		logic [SLOT_W-1:0] tmp;
		int j, extra;
		atom_t a;
		for (int i = 0; i < POOL_N; i++)
			slots.push_back(pool[i]);
		extra = directed ? 0 : $urandom_range(3);
		for (int i = 0; i < extra; i++)
			slots.push_back(pool[$urandom_range(POOL_N-1)]);
		for (int i = slots.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = slots[i];
			slots[i] = slots[j];
			slots[j] = tmp;
		end
		for (int i = 0; i < slots.size(); i++) begin
			a.atom_slot  = slots[i];
			a.frame_time = t;
			a.frame_end  = (i == slots.size() - 1);
			if (directed) begin
				a.pos_x = edge_coord(i + k);
				a.pos_y = edge_coord(i + 2 * k);
				a.pos_z = edge_coord(3 * i + k);
			end else begin
				a.pos_x = move_coord(sent_x[a.atom_slot]);
				a.pos_y = move_coord(sent_y[a.atom_slot]);
				a.pos_z = move_coord(sent_z[a.atom_slot]);
			end
			sent_x[a.atom_slot] = a.pos_x;
			sent_y[a.atom_slot] = a.pos_y;
			sent_z[a.atom_slot] = a.pos_z;
			pending_atoms.push_back(a);
		end
	endtask

	function automatic logic [31:0] pick_box();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'h7FFF_FFFF;
			default: return $urandom_range(20 * 65536, 65536);
		endcase
	endfunction

	initial begin
		logic [31:0] now_t, step_max, lim;
		logic [31:0] dir_times [6];
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		atom_ch.valid = 1'b0;
		atom_ch.data  = '0;
		res_ch.ready  = 1'b0;
		errors = 0;
		box_x_r = 31'd65536;
		box_y_r = 31'd65536;
		box_z_r = 31'd65536;
		group_r = 11'd1;
		starts_r = 5'd1;
		interval_r = 32'd2560;
		limit_r = 16'd10;
		opened_cnt = '0;
		frames_done = '0;
		origin_time = '0;
		mid_frame = 1'b0;
		for (int n = 0; n < MAX_STARTS; n++) begin
			disp_sum[n] = '0;
			opened_at[n] = '0;
		end
		pool[0] = '0;
		pool[1] = 10'h3FF;
		pool[2] = SLOT_W'($urandom_range(511, 1));
		pool[3] = SLOT_W'($urandom_range(1022, 512));
		sender_idle = 35;
		recv_idle   = 75;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// extremes: box edges incl. zero, zero group size, starts above the cap,
		// largest interval reached exactly so the start sum must not wrap
		set_all(32'd1, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd31, 32'hFFFF_FFFF, 32'hFFFF);
		dir_times[0] = 32'd0;
		dir_times[1] = 32'd100;
		dir_times[2] = 32'hFFFF_FFFF;
		dir_times[3] = 32'hFFFF_FFFF;
		dir_times[4] = 32'd7;
		dir_times[5] = 32'hFFFF_FFFE;
		for (int k = 0; k < 6; k++)
			add_frame(dir_times[k], 1'b1, k);
		drain();

		// frames beyond the limit, then a zero limit: all dropped
		write_reg(REG_LIMIT, 32'(frames_done));
		add_frame(32'd500, 1'b0, 0);
		drain();
		write_reg(REG_LIMIT, 32'd0);
		add_frame(32'd600, 1'b0, 0);
		drain();

		now_t = 32'd1000;
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 3) begin
				sender_idle = 75;
				recv_idle   = 35;
			end else if (ph == 6) begin
				sender_idle = 0;
				recv_idle   = 0;
			end
			case ($urandom_range(3))
				0: interval_r = 32'd0;
				1: interval_r = 32'hFFFF_FFFF;
				default: interval_r = $urandom_range(3000, 1);
			endcase
			// one phase cuts off part-way through its frames
			lim = (ph == 4) ? 32'(frames_done + 4) : 32'hFFFF;
			set_all(pick_box(), pick_box(), pick_box(),
				($urandom_range(3) == 0) ? 32'(2047 * $urandom_range(1)) :
					$urandom_range(1024, 1),
				$urandom_range(31), interval_r, lim);
			step_max = $urandom_range(4000);
			for (int f = 0; f < 10; f++) begin
				now_t = now_t + $urandom_range(step_max);
				add_frame(now_t, 1'b0, f);
			end
			drain();
		end

		if (msd_due.size() != 0)
			errors++;
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
